FILE: hw/rtl/drc_pkg.sv
// shared types and constants for the dense rank coalescing block
package drc_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned RANK_W = 6;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned GRP    = 8;
  localparam int unsigned GSUM_W = 4;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/drc_cell.sv
// one cell of the distinct value chain: holds a value, matches and orders a probe
module drc_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  drc_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [drc_pkg::VAL_W-1:0]   left_val_i,
  input  logic                               left_vld_i,
  input  logic signed [drc_pkg::VAL_W-1:0]   probe_i,
  output logic signed [drc_pkg::VAL_W-1:0]   val_o,
  output logic                               vld_o,
  output logic                               eq_o,
  output logic                               lt_o
);

  logic signed [drc_pkg::VAL_W-1:0] val_q;
  logic                             vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      vld_q <= left_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      val_q <= left_val_i;
    end
  end

  assign val_o = val_q;
  assign vld_o = vld_q;
  assign eq_o  = vld_q && (val_q == probe_i);
  assign lt_o  = vld_q && (val_q < probe_i);

endmodule

FILE: hw/rtl/drc_count.sv
// two stage registered count of the cells that hold a smaller value
module drc_count #(
  parameter int unsigned N = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic                        fin_i,
  input  logic [N-1:0]                lt_i,
  output logic                        vld_o,
  output logic                        fin_o,
  output logic [drc_pkg::CNT_W-1:0]   sum_o
);

  localparam int unsigned NGRP  = (N + drc_pkg::GRP - 1) / drc_pkg::GRP;
  localparam int unsigned PAD_W = NGRP * drc_pkg::GRP;

  logic [PAD_W-1:0]                lt_pad;
  logic [drc_pkg::GSUM_W-1:0]      gsum_d [NGRP];
  logic [drc_pkg::GSUM_W-1:0]      gsum_q [NGRP];
  logic                            gvld_q, gfin_q;
  logic [drc_pkg::CNT_W-1:0]       sum_d, sum_q;
  logic                            svld_q, sfin_q;

  assign lt_pad = PAD_W'(lt_i);

  always_comb begin
    logic [drc_pkg::GSUM_W-1:0] acc;
    for (int unsigned g = 0; g < NGRP; g++) begin
      acc = '0;
      for (int unsigned j = 0; j < drc_pkg::GRP; j++) begin
        acc = acc + drc_pkg::GSUM_W'(lt_pad[g*drc_pkg::GRP + j]);
      end
      gsum_d[g] = acc;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int unsigned g = 0; g < NGRP; g++) begin
      sum_d = sum_d + drc_pkg::CNT_W'(gsum_q[g]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gvld_q <= 1'b0;
      gfin_q <= 1'b0;
      svld_q <= 1'b0;
      sfin_q <= 1'b0;
    end else if (en_i) begin
      gvld_q <= vld_i;
      gfin_q <= fin_i;
      svld_q <= gvld_q;
      sfin_q <= gfin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gsum_q <= gsum_d;
      sum_q  <= sum_d;
    end
  end

  assign vld_o = svld_q;
  assign fin_o = sfin_q;
  assign sum_o = sum_q;

endmodule

FILE: hw/rtl/dense_rank_coalesce.sv
// top level: sample store, distinct value cell chain and rank emission
// loading takes one sample per cycle while in_stall_o is low; each sample is registered and
// matched against the chain in the next cycle; after the last sample, results leave at one
// per cycle unless out_stall_i, via store read, compare and group count, total count stages
// the next series is accepted once the final result beat has been taken
// reset clears the counters, the overflow flag and the cell valid bits; stores are not cleared
module dense_rank_coalesce #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [drc_pkg::VAL_W-1:0]    value_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [drc_pkg::RANK_W-1:0]          rank_o,
  output logic [drc_pkg::CNT_W-1:0]           distinct_count_o,
  output logic                                overflow_o,
  output logic                                final_res_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_EMIT  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [drc_pkg::CNT_W-1:0] CAP = drc_pkg::CNT_W'(MAX_ITEMS);

  logic [1:0]                        state_q;
  logic [drc_pkg::CNT_W-1:0]         scnt_q, ucnt_q, rd_idx_q;
  logic                              drop_q;
  logic                              ld_vld_q, ld_last_q;
  logic signed [drc_pkg::VAL_W-1:0]  ld_val_q;
  logic signed [drc_pkg::VAL_W-1:0]  mem [MAX_ITEMS];
  logic signed [drc_pkg::VAL_W-1:0]  rd_data_q;
  logic                              p1_vld_q, p1_fin_q;

  logic                              in_acc, store, ins, hit, en, rd_en, issue_fin, out_done;
  logic                              cnt_vld, cnt_fin;
  logic [drc_pkg::CNT_W-1:0]         cnt_sum;
  logic signed [drc_pkg::VAL_W-1:0]  probe;
  drc_pkg::cell_ctrl_t               cell_ctrl;

  logic signed [drc_pkg::VAL_W-1:0]  cell_val [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]              cell_vld, eq_vec, lt_vec;

  assign in_stall_o = (state_q != ST_LOAD) || (ld_vld_q && ld_last_q);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign store      = ld_vld_q && (scnt_q < CAP);
  assign hit        = |eq_vec;
  assign ins        = store && !hit;
  assign en         = !(cnt_vld && out_stall_i);
  assign rd_en      = (state_q == ST_EMIT) && en;
  assign issue_fin  = (rd_idx_q + drc_pkg::CNT_W'(1)) == scnt_q;
  assign out_done   = cnt_vld && !out_stall_i && cnt_fin;
  assign probe      = (state_q == ST_LOAD) ? ld_val_q : rd_data_q;

  assign cell_ctrl.shift = ins;
  assign cell_ctrl.clear = out_done;

  // new distinct values enter at the head and push the chain along
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    if (k == 0) begin : g_head
      drc_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (cell_ctrl),
        .left_val_i (ld_val_q),
        .left_vld_i (1'b1),
        .probe_i    (probe),
        .val_o      (cell_val[k]),
        .vld_o      (cell_vld[k]),
        .eq_o       (eq_vec[k]),
        .lt_o       (lt_vec[k])
      );
    end else begin : g_body
      drc_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (cell_ctrl),
        .left_val_i (cell_val[k-1]),
        .left_vld_i (cell_vld[k-1]),
        .probe_i    (probe),
        .val_o      (cell_val[k]),
        .vld_o      (cell_vld[k]),
        .eq_o       (eq_vec[k]),
        .lt_o       (lt_vec[k])
      );
    end
  end

  drc_count #(
    .N (MAX_ITEMS)
  ) u_count (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p1_vld_q),
    .fin_i  (p1_fin_q),
    .lt_i   (lt_vec),
    .vld_o  (cnt_vld),
    .fin_o  (cnt_fin),
    .sum_o  (cnt_sum)
  );

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem[scnt_q[IDX_W-1:0]] <= ld_val_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_idx_q[IDX_W-1:0]];
    end
    if (in_acc) begin
      ld_val_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      scnt_q    <= '0;
      ucnt_q    <= '0;
      rd_idx_q  <= '0;
      drop_q    <= 1'b0;
      ld_vld_q  <= 1'b0;
      ld_last_q <= 1'b0;
      p1_vld_q  <= 1'b0;
      p1_fin_q  <= 1'b0;
    end else begin
      ld_vld_q <= in_acc;
      if (in_acc) begin
        ld_last_q <= last_i;
      end
      if (en) begin
        p1_vld_q <= rd_en;
        p1_fin_q <= rd_en && issue_fin;
      end
      case (state_q)
        ST_LOAD: begin
          if (store) begin
            scnt_q <= scnt_q + drc_pkg::CNT_W'(1);
          end
          if (ins) begin
            ucnt_q <= ucnt_q + drc_pkg::CNT_W'(1);
          end
          if (ld_vld_q && !store) begin
            drop_q <= 1'b1;
          end
          if (ld_vld_q && ld_last_q) begin
            state_q  <= ST_EMIT;
            rd_idx_q <= '0;
          end
        end
        ST_EMIT: begin
          if (en) begin
            rd_idx_q <= rd_idx_q + drc_pkg::CNT_W'(1);
            if (issue_fin) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          // final beat taken: open the next series
          if (out_done) begin
            state_q <= ST_LOAD;
            scnt_q  <= '0;
            ucnt_q  <= '0;
            drop_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o      = cnt_vld;
  assign rank_o           = cnt_sum[drc_pkg::RANK_W-1:0];
  assign distinct_count_o = ucnt_q;
  assign overflow_o       = drop_q;
  assign final_res_o      = cnt_fin;

endmodule
